[hw/rtl/quoted_printable_encoder_defines.svh]
// assertion macros for the quoted-printable encoder rtl
`ifndef QUOTED_PRINTABLE_ENCODER_DEFINES_SVH
`define QUOTED_PRINTABLE_ENCODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QPE_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define QPE_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/qpe_pkg.sv]
// types, character codes and helpers for the quoted-printable encoder
package qpe_pkg;

  typedef logic [7:0] char_t;

  localparam int unsigned MaxChars = 6;

  localparam char_t ChCr     = 8'd13;
  localparam char_t ChLf     = 8'd10;
  localparam char_t ChEq     = 8'd61;
  localparam char_t ChDot    = 8'd46;
  localparam char_t LitLoA   = 8'd32;
  localparam char_t LitHiA   = 8'd60;
  localparam char_t LitLoB   = 8'd62;
  localparam char_t LitHiB   = 8'd126;
  localparam char_t LimitRst = 8'd73;

  // expanded characters of one request, lowest index goes out first
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [2:0]               len;
    logic [7:0]               count;
  } seq_t;

  function automatic char_t hex_char(input logic [3:0] nib);
    char_t res;
    if (nib < 4'd10) begin
      res = {4'h0, nib} + 8'h30;
    end else begin
      res = {4'h0, nib} + 8'h37;
    end
    return res;
  endfunction

endpackage

[hw/rtl/quoted_printable_encoder.sv]
// quoted-printable body encoder top level
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    in_byte_i
//   cfg      in   cfg_valid/cfg_ready  line_limit_i
//   out      out  out_valid/out_ready  out_byte_o, out_last_o
//
// a request waits in the input register; its characters leave the result register one
// a cycle while out_ready_i is high, and the next request waits until the last leaves:
// lone literal bytes run at one a cycle then; a soft break, an escape or a line feed
// holds it until all leave. a carriage return produces nothing and needs no room.
// reset clears the column count, the limit returns to 73, both stages empty.
// a stalled output keeps the input register full until its characters drain.
module quoted_printable_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] line_limit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import qpe_pkg::*;
  `include "quoted_printable_encoder_defines.svh"

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic [7:0] count_q, count_d;
  logic [7:0] limit_q, limit_d;
  seq_t       seq;
  logic       free;
  logic       move;
  logic       load;
  logic [2:0] rem;

  qpe_expand u_expand (
    .byte_i  (in_byte_q),
    .count_i (count_q),
    .limit_i (limit_q),
    .seq_o   (seq)
  );

  qpe_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .seq_i       (seq),
    .free_o      (free),
    .rem_o       (rem),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  // a carriage return needs no room in the result register
  assign move        = in_valid_q && ((seq.len == 3'd0) || free);
  assign load        = move && (seq.len != 3'd0);
  assign in_ready_o  = !in_valid_q || move;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    count_d    = count_q;
    limit_d    = limit_q;
    if (move) begin
      in_valid_d = 1'b0;
      count_d    = seq.count;
    end
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      in_byte_d  = in_byte_i;
    end
    if (cfg_valid_i && cfg_ready_o) begin
      limit_d = line_limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      count_q    <= 8'd0;
      limit_q    <= LimitRst;
    end else begin
      in_valid_q <= in_valid_d;
      count_q    <= count_d;
      limit_q    <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
  end

  `QPE_ASSERT_IMP(a_rem_range, out_valid_o, (rem >= 3'd1) && (rem <= 3'd6),
    "result register holds an impossible character count")
  `QPE_ASSERT_NXT(a_in_hold, in_valid_q && !move, in_valid_q && $stable(in_byte_q),
    "input register lost a request while the result register was busy")
  `QPE_ASSERT_NXT(a_lf_clear, move && (in_byte_q == ChLf), count_q == 8'd0,
    "line feed did not clear the column count")
  `QPE_ASSERT_NXT(a_soft_break,
    move && (count_q > limit_q) && (in_byte_q != ChCr) && (in_byte_q != ChLf),
    count_q <= 8'd3, "soft break did not restart the column count")

endmodule

[hw/rtl/qpe_expand.sv]
// turns one body byte and the column count into its encoded characters
module qpe_expand (
  input  logic [7:0]    byte_i,
  input  logic [7:0]    count_i,
  input  logic [7:0]    limit_i,
  output qpe_pkg::seq_t seq_o
);
  import qpe_pkg::*;

  logic       brk;
  logic       lit;
  logic [7:0] base;
  logic [8:0] sum;
  logic [7:0] sat;

  always_comb begin
    brk  = count_i > limit_i;
    lit  = (byte_i inside {[LitLoA:LitHiA], [LitLoB:LitHiB]}) && (byte_i != ChDot);
    base = brk ? 8'd0 : count_i;
    sum  = {1'b0, base} + (lit ? 9'd1 : 9'd3);
    sat  = sum[8] ? 8'hff : sum[7:0];
  end

  always_comb begin
    seq_o       = '0;
    seq_o.count = count_i;
    if (byte_i == ChCr) begin
      seq_o.len = 3'd0;
    end else if (byte_i == ChLf) begin
      seq_o.chars[0] = ChCr;
      seq_o.chars[1] = ChLf;
      seq_o.len      = 3'd2;
      seq_o.count    = 8'd0;
    end else if (brk) begin
      // soft break ahead of the byte
      seq_o.chars[0] = ChEq;
      seq_o.chars[1] = ChCr;
      seq_o.chars[2] = ChLf;
      seq_o.count    = sat;
      if (lit) begin
        seq_o.chars[3] = byte_i;
        seq_o.len      = 3'd4;
      end else begin
        seq_o.chars[3] = ChEq;
        seq_o.chars[4] = hex_char(byte_i[7:4]);
        seq_o.chars[5] = hex_char(byte_i[3:0]);
        seq_o.len      = 3'd6;
      end
    end else begin
      seq_o.count = sat;
      if (lit) begin
        seq_o.chars[0] = byte_i;
        seq_o.len      = 3'd1;
      end else begin
        seq_o.chars[0] = ChEq;
        seq_o.chars[1] = hex_char(byte_i[7:4]);
        seq_o.chars[2] = hex_char(byte_i[3:0]);
        seq_o.len      = 3'd3;
      end
    end
  end

endmodule

[hw/rtl/qpe_serial.sv]
// result register: holds the expanded characters and hands them out one a cycle while out_ready_i is high
module qpe_serial (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  qpe_pkg::seq_t seq_i,
  output logic          free_o,
  output logic [2:0]    rem_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o
);
  import qpe_pkg::*;

  logic [MaxChars-1:0][7:0] chars_q, chars_d;
  logic [2:0]               rem_q, rem_d;
  logic                     fire;

  assign fire        = out_valid_o && out_ready_i;
  assign out_valid_o = rem_q != 3'd0;
  assign out_byte_o  = chars_q[0];
  assign out_last_o  = rem_q == 3'd1;
  // empty, or the last character leaves this cycle
  assign free_o      = (rem_q == 3'd0) || (out_last_o && out_ready_i);
  assign rem_o       = rem_q;

  always_comb begin
    chars_d = chars_q;
    rem_d   = rem_q;
    if (load_i) begin
      chars_d = seq_i.chars;
      rem_d   = seq_i.len;
    end else if (fire) begin
      chars_d[MaxChars-2:0] = chars_q[MaxChars-1:1];
      chars_d[MaxChars-1]   = '0;
      rem_d                 = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

endmodule

[test/testbench.sv]
// self-checking testbench for the quoted-printable body encoder
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qpe_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned MaxReported = 10;

  typedef struct {
    char_t ch;
    logic  last;
  } enc_char_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  char_t in_byte = '0;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  char_t cfg_limit = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  char_t out_char;
  logic  out_last;

  // mirror of the block state
  char_t col_count = '0;
  char_t limit_reg = LimitRst;

  enc_char_t   encoded_chars[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_active = 1'b0;

  quoted_printable_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_byte_i    (in_byte),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .line_limit_i (cfg_limit),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_char),
    .out_last_o   (out_last)
  );

  always #2 clk_i = ~clk_i;

  function automatic char_t hex_digit(input logic [3:0] nib);
    if (nib > 4'd9) begin
      return char_t'(nib) + 8'd55;
    end
    return char_t'(nib) + 8'd48;
  endfunction

  function automatic void add_char(input char_t c);
    enc_char_t e;
    e.ch   = c;
    e.last = 1'b0;
    encoded_chars.push_back(e);
  endfunction

  function automatic void bump_count(input int unsigned amount);
    int unsigned sum;
    sum = int'(col_count) + amount;
    col_count = (sum > 255) ? 8'd255 : char_t'(sum);
  endfunction

  // work out the characters that one accepted request produces
  function automatic void predict_encoding(input char_t b);
    int unsigned before_len;
    logic        literal;
    before_len = encoded_chars.size();
    if (b == ChLf) begin
      add_char(ChCr);
      add_char(ChLf);
      col_count = '0;
    end else if (b != ChCr) begin
      if (col_count > limit_reg) begin
        add_char(ChEq);
        add_char(ChCr);
        add_char(ChLf);
        col_count = '0;
      end
      literal = (b != ChDot) &&
                ((b >= LitLoA && b <= LitHiA) || (b >= LitLoB && b <= LitHiB));
      if (literal) begin
        add_char(b);
        bump_count(1);
      end else begin
        add_char(ChEq);
        add_char(hex_digit(b[7:4]));
        add_char(hex_digit(b[3:0]));
        bump_count(3);
      end
    end
    if (encoded_chars.size() > before_len) begin
      encoded_chars[encoded_chars.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReported) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  // output side: compare every accepted character with the oldest prediction
  always @(posedge clk_i) begin
    enc_char_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (encoded_chars.size() == 0) begin
        note_failure($sformatf("unexpected char %02h last %0b", out_char, out_last));
      end else begin
        want = encoded_chars.pop_front();
        if (out_char !== want.ch) begin
          note_failure($sformatf("char expected %02h, got %02h", want.ch, out_char));
        end
        if (out_last !== want.last) begin
          note_failure($sformatf("last flag on %02h expected %0b, got %0b",
                                 want.ch, want.last, out_last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready <= !hold_active && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off, counted here
  always begin
    wait (hold_go);
    hold_active <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active <= 1'b0;
    hold_go = 1'b0;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("quoted_printable_encoder verification failed");
    $finish;
  end

  task automatic send_byte(input char_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    predict_encoding(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (encoded_chars.size() != 0) @(posedge clk_i);
    // a trailing carriage return leaves no result to wait for
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_line_limit(input char_t value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_limit <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = value;
  endtask

  task automatic test_directed_bytes();
    char_t picks[$];
    picks = '{8'h00, 8'hFF, ChCr, ChLf, ChDot, LitLoA, LitHiA, ChEq, LitLoB, LitHiB,
              8'h7F, 8'h1F, 8'h09, 8'h80, 8'h41, ChCr, ChLf, 8'hAA, 8'h55};
    idle_pct  = 0;
    stall_pct = 0;
    foreach (picks[i]) send_byte(picks[i]);
    wait_drained();
  endtask

  task automatic test_limit_extremes();
    set_line_limit(8'd1);
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(8'h43);
    send_byte(8'hFF);
    send_byte(8'h44);
    // zero breaks before every byte once the line holds anything
    set_line_limit(8'd0);
    send_byte(8'h78);
    send_byte(8'h79);
    send_byte(ChCr);
    send_byte(8'h00);
    send_byte(ChLf);
    send_byte(8'h7A);
    set_line_limit(8'd252);
    send_byte(8'h61);
    send_byte(ChDot);
    send_byte(ChLf);
  endtask

  task automatic test_count_saturation();
    set_line_limit(8'd255);
    repeat (86) send_byte(8'hFF);
    send_byte(8'h51);
    // count is stuck at its ceiling, so the next limit forces a break
    set_line_limit(8'd252);
    send_byte(8'h52);
    send_byte(ChLf);
  endtask

  task automatic test_backpressure();
    set_line_limit(8'd10);
    idle_pct  = 0;
    stall_pct = 0;
    hold_go   = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_byte((i % 3 == 0) ? 8'hFF : ((i % 5 == 0) ? ChLf : 8'h41 + char_t'(i)));
    end
    // sender holds back until everything has drained
    wait_drained();
    repeat (3) send_byte(8'h30);
    wait_drained();
  endtask

  task automatic test_random_text();
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    int unsigned r;
    char_t       b;
    idle_set  = '{0, 48, 0, 34};
    stall_set = '{0, 0, 48, 34};
    for (int phase = 0; phase < 4; phase++) begin
      set_line_limit($urandom_range(1) ? char_t'($urandom_range(1, 40))
                                       : char_t'($urandom_range(1, 252)));
      idle_pct  = idle_set[phase];
      stall_pct = stall_set[phase];
      for (int i = 0; i < 8; i++) begin
        r = $urandom_range(99);
        if (r < 65) begin
          b = char_t'($urandom_range(LitLoA, LitHiB));
        end else if (r < 75) begin
          b = ChLf;
        end else if (r < 80) begin
          b = ChCr;
        end else begin
          b = char_t'($urandom_range(0, 255));
        end
        send_byte(b);
        if ($urandom_range(39) == 0) begin
          wait_drained();
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_bytes();
    test_limit_extremes();
    test_count_saturation();
    test_backpressure();
    test_random_text();
    set_line_limit(LimitRst);
    if (fail_count == 0 && encoded_chars.size() == 0) begin
      $display("quoted_printable_encoder verification clean");
    end else begin
      $display("quoted_printable_encoder verification failed");
    end
    $finish;
  end

endmodule
